// ===== rtl/core/tilt_filter_led_bar_core_defines.svh =====
// assertion macros for the tilt filter led bar core
`ifndef TILT_FILTER_LED_BAR_CORE_DEFINES_SVH
`define TILT_FILTER_LED_BAR_CORE_DEFINES_SVH

// same-cycle implication, off while in reset
`define TFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfl: same-cycle property failed");

// next-cycle implication, checked also through reset
`define TFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tfl: next-cycle property failed");

`endif

// ===== rtl/core/tfl_pkg.sv =====
// package with widths, register indexes and the filter update for the tilt filter core
package tfl_pkg;

  localparam int RAW_W    = 8;
  localparam int SMOOTH_W = 12;
  localparam int OFFS_W   = 12;
  localparam int CORR_W   = 13;
  localparam int LED_W    = 16;
  localparam int ACC_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int LED_COUNT_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

  // new = (7*old + 16*raw) >>> 3
  function automatic logic signed [SMOOTH_W-1:0] iir_next(
    input logic signed [SMOOTH_W-1:0] old,
    input logic signed [RAW_W-1:0]    raw
  );
    logic signed [ACC_W-1:0] ext;
    logic signed [ACC_W-1:0] acc;
    ext = {{(ACC_W-SMOOTH_W){old[SMOOTH_W-1]}}, old};
    acc = (ext <<< 3) - ext + {{(ACC_W-RAW_W-4){raw[RAW_W-1]}}, raw, 4'b0000};
    return acc[SMOOTH_W+2:3];
  endfunction

endpackage

// ===== rtl/core/tfl_if.sv =====
// request channels of the tilt filter core: samples in, corrected results out
interface tfl_in_if import tfl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] raw_x;
  logic signed [RAW_W-1:0] raw_y;
  logic signed [RAW_W-1:0] raw_z;

  modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface tfl_out_if import tfl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CORR_W-1:0] corrected_x;
  logic signed [CORR_W-1:0] corrected_y;
  logic signed [CORR_W-1:0] corrected_z;
  logic        [LED_W-1:0]  led_pattern;

  modport source (output valid, output corrected_x, output corrected_y,
                  output corrected_z, output led_pattern, input ready);
  modport sink   (input valid, input corrected_x, input corrected_y,
                  input corrected_z, input led_pattern, output ready);
endinterface

// ===== rtl/core/tilt_filter_led_bar_core.sv =====
// tilt filter core: per-axis iir smoothing, offset correction and led bar
// a sample's result is registered in the filter stage, then in the output stage; a stall can hold it between
// throughput: one sample per cycle while the results are taken; the filter registers update on acceptance
// a stalled result holds the pipeline, samples keep flowing while a slot is free
// reset (synchronous, active high) clears filter state, offsets and valid flags
module tilt_filter_led_bar_core import tfl_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OFFS_W-1:0]    cfg_data,
  tfl_in_if.sink               samples,
  tfl_out_if.source            results
);

  logic signed [SMOOTH_W-1:0] smooth_x, smooth_y, smooth_z;
  logic signed [OFFS_W-1:0]   offset_x, offset_y, offset_z;
  logic                       mid_valid;
  logic                       out_valid;
  logic                       out_adv;
  logic                       in_take;

  logic signed [CORR_W-1:0] corr_x_next, corr_y_next, corr_z_next;
  logic signed [5:0]        bar_n;
  logic signed [7:0]        bar_lo, bar_hi;
  logic        [LED_W-1:0]  led_next;

  logic signed [CORR_W-1:0] corrected_x, corrected_y, corrected_z;
  logic        [LED_W-1:0]  led_pattern;

  assign out_adv       = !out_valid || results.ready;
  assign samples.ready = !mid_valid || out_adv;
  assign in_take       = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        REG_OFFSET_Z: offset_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_x  <= '0;
      smooth_y  <= '0;
      smooth_z  <= '0;
      mid_valid <= 1'b0;
    end else begin
      if (in_take) begin
        smooth_x <= iir_next(smooth_x, samples.raw_x);
        smooth_y <= iir_next(smooth_y, samples.raw_y);
        smooth_z <= iir_next(smooth_z, samples.raw_z);
      end
      if (samples.ready) begin
        mid_valid <= in_take;
      end
    end
  end

  always_comb begin
    corr_x_next = {smooth_x[SMOOTH_W-1], smooth_x} - {offset_x[OFFS_W-1], offset_x};
    corr_y_next = {smooth_y[SMOOTH_W-1], smooth_y} - {offset_y[OFFS_W-1], offset_y};
    corr_z_next = {smooth_z[SMOOTH_W-1], smooth_z} - {offset_z[OFFS_W-1], offset_z};
    bar_n  = corr_y_next[CORR_W-1:7];
    bar_lo = 8'sd7;
    bar_hi = 8'sd7;
    if (bar_n > 6'sd0) begin
      bar_hi = 8'sd6 + $signed({{2{bar_n[5]}}, bar_n});
    end else if (bar_n < 6'sd0) begin
      bar_lo = 8'sd8 + $signed({{2{bar_n[5]}}, bar_n});
    end
    for (int b = 0; b < LED_W; b++) begin
      led_next[b] = ($signed(8'(b)) >= bar_lo) && ($signed(8'(b)) <= bar_hi)
                    && (b < LED_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && mid_valid) begin
      corrected_x <= corr_x_next;
      corrected_y <= corr_y_next;
      corrected_z <= corr_z_next;
      led_pattern <= led_next;
    end
  end

  assign results.valid       = out_valid;
  assign results.corrected_x = corrected_x;
  assign results.corrected_y = corrected_y;
  assign results.corrected_z = corrected_z;
  assign results.led_pattern = led_pattern;

endmodule

// ===== rtl/core/tfl_checker.sv =====
// port checker for the tilt filter core and its bind
`include "tilt_filter_led_bar_core_defines.svh"

module tfl_checker import tfl_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [CORR_W-1:0] corrected_x,
  input logic signed [CORR_W-1:0] corrected_y,
  input logic        [LED_W-1:0]  led_pattern
);

  // no result survives reset
  `TFL_ASSERT_NEXT(a_rst_clears, rst, !out_valid)
  // the middle led is always part of the bar
  `TFL_ASSERT_NOW(a_mid_led_on, out_valid, led_pattern[7])
  // a negative tilt never lights above the middle
  `TFL_ASSERT_NOW(a_neg_no_up, out_valid && corrected_y[CORR_W-1], !led_pattern[8])
  // a stalled result holds
  `TFL_ASSERT_NEXT(a_stall_hold, !rst && out_valid && !out_ready,
    rst || (out_valid && $stable(corrected_x) && $stable(led_pattern)))

endmodule

bind tilt_filter_led_bar_core tfl_checker u_tfl_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .corrected_x (results.corrected_x),
  .corrected_y (results.corrected_y),
  .led_pattern (results.led_pattern)
);

// ===== test/tb_top.sv =====
// testbench for the tilt filter led bar core: predicted results checked against the output channel
module tb_top;
  import tfl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LED_COUNT   = 16;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 150;
  localparam int CALM_PHASE  = 4;
  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
    logic signed [RAW_W-1:0] z;
  } sample_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] cx;
    logic signed [CORR_W-1:0] cy;
    logic signed [CORR_W-1:0] cz;
    logic [LED_W-1:0]         led;
  } tilt_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OFFS_W-1:0] cfg_data = '0;

  tfl_in_if samples_if ();
  tfl_out_if results_if ();

  tilt_filter_led_bar_core #(.LED_COUNT(LED_COUNT)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .results   (results_if)
  );

  sample_t      sample_q[$];
  tilt_result_t corrected_q[$];

  logic signed [SMOOTH_W-1:0] smooth_x = '0, smooth_y = '0, smooth_z = '0;
  logic signed [OFFS_W-1:0]   off_x = '0, off_y = '0, off_z = '0;

  bit calm = 1'b0;
  int errors = 0;
  int results_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  int run_left[3];
  int run_mode[3];
  logic signed [RAW_W-1:0] run_level[3];

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic signed [SMOOTH_W-1:0] smooth_next(
    input logic signed [SMOOTH_W-1:0] prev,
    input logic signed [RAW_W-1:0]    raw
  );
    int acc;
    acc = 7 * int'(prev) + 16 * int'(raw);
    return SMOOTH_W'(acc >>> 3);
  endfunction

  function automatic logic [LED_W-1:0] led_bar(input logic signed [CORR_W-1:0] cy);
    int n;
    int lo;
    int hi;
    logic [LED_W-1:0] bar;
    n = int'(cy) >>> 7;
    lo = 7;
    hi = 7;
    if (n > 0) begin
      hi = 6 + n;
    end else if (n < 0) begin
      lo = 8 + n;
    end
    if (hi > LED_COUNT - 1) hi = LED_COUNT - 1;
    if (lo < 0) lo = 0;
    bar = '0;
    for (int b = lo; b <= hi && b < LED_W; b++) bar[b] = 1'b1;
    return bar;
  endfunction

  // advances the filter state and returns the corrected outputs for one sample
  function automatic tilt_result_t tilt_step(input sample_t s);
    tilt_result_t r;
    smooth_x = smooth_next(smooth_x, s.x);
    smooth_y = smooth_next(smooth_y, s.y);
    smooth_z = smooth_next(smooth_z, s.z);
    r.cx  = CORR_W'(int'(smooth_x) - int'(off_x));
    r.cy  = CORR_W'(int'(smooth_y) - int'(off_y));
    r.cz  = CORR_W'(int'(smooth_z) - int'(off_z));
    r.led = led_bar(r.cy);
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (errors < 10) $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFFS_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_OFFSET_X: off_x = val;
      REG_OFFSET_Y: off_y = val;
      REG_OFFSET_Z: off_z = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_sample(input int x, input int y, input int z);
    sample_t s;
    s.x = RAW_W'(x);
    s.y = RAW_W'(y);
    s.z = RAW_W'(z);
    sample_q.push_back(s);
  endtask

  // runs of held levels drive the filters to their extremes, mixed with noise
  task automatic queue_random(input int count);
    int v[3];
    for (int i = 0; i < count; i++) begin
      for (int a = 0; a < 3; a++) begin
        if (run_left[a] == 0) begin
          run_mode[a] = $urandom_range(2);
          run_left[a] = $urandom_range(40, 1);
          if ($urandom_range(2) == 0) begin
            run_level[a] = $urandom_range(1) ? 8'sd127 : -8'sd128;
          end else begin
            run_level[a] = RAW_W'($urandom);
          end
        end
        run_left[a]--;
        case (run_mode[a])
          0: v[a] = run_level[a];
          1: v[a] = int'(run_level[a]) + int'($urandom_range(6)) - 3;
          default: v[a] = $urandom_range(255);
        endcase
      end
      push_sample(v[0], v[1], v[2]);
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || samples_if.valid || corrected_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
    end else begin
      if (samples_if.valid && samples_if.ready) begin
        corrected_q.push_back(tilt_step({samples_if.raw_x, samples_if.raw_y, samples_if.raw_z}));
      end
      if (!samples_if.valid || samples_if.ready) begin
        if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
          sample_t s;
          s = sample_q.pop_front();
          samples_if.valid <= 1'b1;
          samples_if.raw_x <= s.x;
          samples_if.raw_y <= s.y;
          samples_if.raw_z <= s.z;
        end else begin
          samples_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        results_seen++;
        if (corrected_q.size() == 0) begin
          if (errors < 10) $display("result request with nothing expected");
          errors++;
        end else begin
          tilt_result_t want;
          want = corrected_q.pop_front();
          check_field("corrected_x", want.cx, results_if.corrected_x);
          check_field("corrected_y", want.cy, results_if.corrected_y);
          check_field("corrected_z", want.cz, results_if.corrected_z);
          check_field("led_pattern", int'(want.led), int'(results_if.led_pattern));
        end
        // long back-pressure so the pipeline fills and stalls the input
        if (results_seen == 400 || results_seen == 1100) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= calm || $urandom_range(99) >= 15;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    samples_if.valid = 1'b0;
    samples_if.raw_x = '0;
    samples_if.raw_y = '0;
    samples_if.raw_z = '0;
    results_if.ready = 1'b0;
    for (int a = 0; a < 3; a++) begin
      run_left[a] = 0;
      run_mode[a] = 0;
      run_level[a] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset offsets: bar grows up past the top led, then down past bit 0
    push_sample(0, 0, 0);
    repeat (10) push_sample(127, 127, -128);
    repeat (10) push_sample(-128, -128, 127);
    push_sample(1, -1, 0);
    push_sample(-1, 1, 0);
    push_sample(64, -64, -1);
    push_sample(0, 0, 0);
    drain();

    for (int p = 1; p <= PHASES; p++) begin
      case (p)
        1: begin
          write_reg(REG_OFFSET_X, -12'sd2048);
          write_reg(REG_OFFSET_Y, -12'sd2048);
          write_reg(REG_OFFSET_Z, -12'sd2048);
        end
        2: begin
          write_reg(REG_OFFSET_X, 12'sd2047);
          write_reg(REG_OFFSET_Y, 12'sd2047);
          write_reg(REG_OFFSET_Z, 12'sd2047);
        end
        3: begin
          write_reg(REG_OFFSET_X, 12'sd2032);
          write_reg(REG_OFFSET_Y, -12'sd2048);
          write_reg(REG_OFFSET_Z, 12'sd0);
        end
        4: begin
          write_reg(REG_OFFSET_X, 12'sd0);
          write_reg(REG_OFFSET_Y, 12'sd2032);
          write_reg(REG_OFFSET_Z, -12'sd1);
        end
        default: begin
          write_reg(REG_OFFSET_X, OFFS_W'($urandom));
          write_reg(REG_OFFSET_Y, OFFS_W'($urandom));
          write_reg(REG_OFFSET_Z, OFFS_W'($urandom));
        end
      endcase
      // writes to the unused index must be ignored
      write_reg(REG_UNUSED, OFFS_W'($urandom));
      calm = (p == CALM_PHASE);
      queue_random(PHASE_ITEMS);
      drain();
    end

    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tfl_pkg.sv
rtl/core/tfl_if.sv
rtl/core/tilt_filter_led_bar_core.sv
rtl/core/tfl_checker.sv
test/tb_top.sv
